@@ sv/hpt_pkg.sv @@
// ----------------------------------------------------------------------------
// hpt_pkg: shared types and constants of the HDR pixel tone mapper
// Register indexes, operator codes, pipeline depths and the item record
// handed from the front end through the queue to the arithmetic back end.
// ----------------------------------------------------------------------------
package hpt_pkg;

   localparam int SAMPLE_BITS_DEF = 32;
   localparam int QUEUE_DEPTH     = 2;
   localparam int CHANNELS        = 3;

   // restoring divider steps for (x << 16) / divisor
   localparam int DIV_STAGES  = 48;
   // stages between the normalised value and the final select
   localparam int LOG_STAGES  = 22;
   // quotient bits of the Reinhard divider
   localparam int RH_STEPS    = 17;
   localparam int FRAC_BITS   = 16;
   localparam int BACK_STAGES = DIV_STAGES + LOG_STAGES + 2;

   localparam logic [2:0] MODE_CLAMP       = 3'd0;
   localparam logic [2:0] MODE_EQUALIZE    = 3'd1;
   localparam logic [2:0] MODE_CLAMP_NORM  = 3'd2;
   localparam logic [2:0] MODE_GAMMA       = 3'd3;
   localparam logic [2:0] MODE_CLAMP_GAMMA = 3'd4;
   localparam logic [2:0] MODE_REINHARD    = 3'd5;

   localparam logic [1:0] REG_MODE        = 2'd0;
   localparam logic [1:0] REG_CLAMP_LEVEL = 2'd1;
   localparam logic [1:0] REG_IMAGE_MAX   = 2'd2;
   localparam logic [1:0] REG_GAMMA       = 2'd3;

   localparam logic [31:0] ONE_Q = 32'd65536;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] clamp_level;
      logic [31:0] image_max;
      logic [15:0] gamma_exponent;
   } cfg_type;

   typedef struct packed {
      logic [2:0]                mode;
      logic                      sel_im;
      logic [CHANNELS-1:0]       over;
      logic [CHANNELS-1:0][31:0] x;
      logic [CHANNELS-1:0][31:0] bypass;
   } item_type;

   function automatic logic [31:0] ceil_value(input int sample_bits);
      logic [31:0] c;
      if (sample_bits >= 32) begin
         c = 32'hFFFF_FFFF;
      end else begin
         c = (32'd1 << sample_bits) - 32'd1;
      end
      return c;
   endfunction

endpackage

@@ sv/hdr_pixel_tone_mapper_top.sv @@
// ----------------------------------------------------------------------------
// hdr_pixel_tone_mapper_top: HDR pixel tone mapper
// Maps unsigned Q16.16 RGB radiance to a display range with one of six
// operators selected by the mode register.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one pixel per transfer (valid high, stall low); rsp_*
//   returns the mapped pixel in the same order, one result per pixel.
//   csr_write with csr_index/csr_wdata sets mode, clamp level, image
//   maximum and gamma exponent; write only while no pixel is in flight.
//   Throughput is one pixel per clock while rsp_stall is low. From the
//   req transfer to rsp_valid a pixel passes the front register, one
//   queue slot, 48 divider steps, one select stage, two log2 normalising
//   stages, 16 squaring stages, one exponent multiply, three exp2
//   polynomial stages and the result register.
//   While rsp_stall holds a result, the whole back pipeline holds; the
//   front register and the two-entry queue keep taking pixels until full.
//   Synchronous reset empties the pipeline and loads the register
//   defaults: mode clamp-normalise, clamp level 1.0, image maximum 1.0,
//   gamma 1.0.
// ----------------------------------------------------------------------------
module hdr_pixel_tone_mapper_top #(
   parameter int SAMPLE_BITS = hpt_pkg::SAMPLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_red_in,
   input  logic [31:0] req_green_in,
   input  logic [31:0] req_blue_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_red_out,
   output logic [31:0] rsp_green_out,
   output logic [31:0] rsp_blue_out,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   hpt_pkg::cfg_type  cfg_ff, cfg_in;
   logic              push_valid, push_ready, pop, pop_valid;
   hpt_pkg::item_type push_item, pop_item;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            hpt_pkg::REG_MODE:        cfg_in.mode           = csr_wdata[2:0];
            hpt_pkg::REG_CLAMP_LEVEL: cfg_in.clamp_level    = csr_wdata;
            hpt_pkg::REG_IMAGE_MAX:   cfg_in.image_max      = csr_wdata;
            hpt_pkg::REG_GAMMA:       cfg_in.gamma_exponent = csr_wdata[15:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode           <= hpt_pkg::MODE_CLAMP_NORM;
         cfg_ff.clamp_level    <= hpt_pkg::ONE_Q;
         cfg_ff.image_max      <= hpt_pkg::ONE_Q;
         cfg_ff.gamma_exponent <= 16'd4096;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hpt_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_red_in   (req_red_in),
      .req_green_in (req_green_in),
      .req_blue_in  (req_blue_in),
      .push_ready   (push_ready),
      .push_valid   (push_valid),
      .push_item    (push_item)
   );

   hpt_queue #(
      .DEPTH (hpt_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item)
   );

   hpt_back #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .pop_valid     (pop_valid),
      .pop           (pop),
      .pop_item      (pop_item),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out)
   );

endmodule

@@ sv/hpt_front.sv @@
// ----------------------------------------------------------------------------
// hpt_front: input stage of the tone mapper
// Takes a pixel, picks the divisor, flags channels above the clamp level
// and forms the pass-through values, then hands the item to the queue.
// ----------------------------------------------------------------------------
module hpt_front #(
   parameter int SAMPLE_BITS = hpt_pkg::SAMPLE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  hpt_pkg::cfg_type   cfg,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [31:0]        req_red_in,
   input  logic [31:0]        req_green_in,
   input  logic [31:0]        req_blue_in,
   input  logic               push_ready,
   output logic               push_valid,
   output hpt_pkg::item_type  push_item
);

   localparam logic [31:0] CEIL = hpt_pkg::ceil_value(SAMPLE_BITS);

   logic              valid_ff, valid_in;
   hpt_pkg::item_type item_ff, item_in;
   logic              load;
   logic [hpt_pkg::CHANNELS-1:0][31:0] px;

   assign px         = {req_blue_in, req_green_in, req_red_in};
   assign load       = !valid_ff || push_ready;
   assign req_stall  = !load;
   assign push_valid = valid_ff;
   assign push_item  = item_ff;

   always_comb begin
      logic [31:0] mn;
      item_in        = item_ff;
      item_in.mode   = cfg.mode;
      item_in.sel_im = (cfg.mode == hpt_pkg::MODE_EQUALIZE) ||
                       (cfg.mode == hpt_pkg::MODE_GAMMA);
      for (int c = 0; c < hpt_pkg::CHANNELS; c++) begin
         mn                = (px[c] < cfg.clamp_level) ? px[c] : cfg.clamp_level;
         item_in.x[c]      = px[c];
         item_in.over[c]   = px[c] > cfg.clamp_level;
         if (cfg.mode == hpt_pkg::MODE_CLAMP) begin
            item_in.bypass[c] = (mn > CEIL) ? CEIL : mn;
         end else begin
            item_in.bypass[c] = (px[c] > CEIL) ? CEIL : px[c];
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

@@ sv/hpt_queue.sv @@
// ----------------------------------------------------------------------------
// hpt_queue: short FIFO between front end and back end
// Lets the front take a pixel while the back end is frozen, and the
// reverse.
// ----------------------------------------------------------------------------
module hpt_queue #(
   parameter int DEPTH = hpt_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  hpt_pkg::item_type push_item,
   input  logic              pop,
   output logic              pop_valid,
   output hpt_pkg::item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   hpt_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push;

   assign push_ready = count_ff < CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ sv/hpt_chan.sv @@
// ----------------------------------------------------------------------------
// hpt_chan: arithmetic pipeline of one colour channel
// Pipelined restoring divider, log2 by repeated squaring, exponent
// multiply, exp2 polynomial, Reinhard divider alongside, final select.
// ----------------------------------------------------------------------------
module hpt_chan #(
   parameter int SAMPLE_BITS = hpt_pkg::SAMPLE_BITS_DEF
) (
   input  logic             clock,
   input  logic             en,
   input  hpt_pkg::cfg_type cfg,
   input  logic [2:0]       mode,
   input  logic             sel_im,
   input  logic             over,
   input  logic [31:0]      x,
   input  logic [31:0]      bypass,
   output logic [31:0]      res
);

   localparam logic [31:0] CEIL    = hpt_pkg::ceil_value(SAMPLE_BITS);
   localparam logic [31:0] ONE_SAT = (CEIL < hpt_pkg::ONE_Q) ? CEIL : hpt_pkg::ONE_Q;
   localparam int DS = hpt_pkg::DIV_STAGES;
   localparam int LS = hpt_pkg::LOG_STAGES;
   localparam int FB = hpt_pkg::FRAC_BITS;

   typedef struct packed {
      logic [31:0] rem;
      logic [47:0] nq;
      logic [31:0] bypass;
      logic [2:0]  mode;
      logic        sel_im;
      logic        over;
   } div_stage_type;

   typedef struct packed {
      logic [31:0] y;
      logic [31:0] bypass;
      logic [2:0]  mode;
   } side_type;

   typedef struct packed {
      logic [17:0] rem;
      logic [16:0] nq;
   } rh_type;

   typedef struct packed {
      logic [16:0]        m;
      logic signed [4:0]  e;
      logic [FB-1:0]      frac;
   } sq_type;

   // ---------------- divider ----------------
   div_stage_type div_src [DS];
   div_stage_type div_ff  [DS];
   div_stage_type div_in  [DS];

   genvar s;
   generate
      for (s = 0; s < DS; s++) begin : g_div
         if (s == 0) begin : g_seed
            assign div_src[s] = '{rem: '0, nq: {x, 16'd0}, bypass: bypass,
                                  mode: mode, sel_im: sel_im, over: over};
         end else begin : g_link
            assign div_src[s] = div_ff[s-1];
         end

         always_comb begin
            logic [32:0] trial, dsor, diff;
            logic        ge;
            dsor  = {1'b0, div_src[s].sel_im ? cfg.image_max : cfg.clamp_level};
            trial = {div_src[s].rem, div_src[s].nq[47]};
            diff  = trial - dsor;
            ge    = trial >= dsor;
            div_in[s]     = div_src[s];
            div_in[s].rem = ge ? diff[31:0] : trial[31:0];
            div_in[s].nq  = {div_src[s].nq[46:0], ge};
         end

         always_ff @(posedge clock) begin
            if (en) begin
               div_ff[s] <= div_in[s];
            end
         end
      end
   endgenerate

   // ---------------- normalised value ----------------
   side_type y_ff, y_in;

   always_comb begin
      logic [47:0] q;
      logic [31:0] satq;
      logic        dzero;
      q     = div_ff[DS-1].nq;
      satq  = (q > {16'd0, CEIL}) ? CEIL : q[31:0];
      dzero = div_ff[DS-1].sel_im ? (cfg.image_max == '0) : (cfg.clamp_level == '0);
      y_in.bypass = div_ff[DS-1].bypass;
      y_in.mode   = div_ff[DS-1].mode;
      y_in.y      = ((div_ff[DS-1].over && !div_ff[DS-1].sel_im) || dzero) ?
                    ONE_SAT : satq;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff <= y_in;
      end
   end

   // ---------------- side band and Reinhard divider ----------------
   side_type side_src [LS];
   side_type side_ff  [LS];
   rh_type   rh_src   [LS];
   rh_type   rh_ff    [LS];
   rh_type   rh_in    [LS];

   generate
      for (s = 0; s < LS; s++) begin : g_side
         if (s == 0) begin : g_seed
            assign side_src[s] = y_ff;
            assign rh_src[s]   = '{rem: {2'd0, y_ff.y[16:1]}, nq: {y_ff.y[0], 16'd0}};
         end else begin : g_link
            assign side_src[s] = side_ff[s-1];
            assign rh_src[s]   = rh_ff[s-1];
         end

         if (s < hpt_pkg::RH_STEPS) begin : g_step
            always_comb begin
               logic [18:0] trial, dsor, diff;
               logic        ge;
               dsor  = 19'(hpt_pkg::ONE_Q) + {2'd0, side_src[s].y[16:0]};
               trial = {rh_src[s].rem, rh_src[s].nq[16]};
               diff  = trial - dsor;
               ge    = trial >= dsor;
               rh_in[s].rem = ge ? diff[17:0] : trial[17:0];
               rh_in[s].nq  = {rh_src[s].nq[15:0], ge};
            end
         end else begin : g_hold
            always_comb begin
               rh_in[s] = rh_src[s];
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               side_ff[s] <= side_src[s];
               rh_ff[s]   <= rh_in[s];
            end
         end
      end
   endgenerate

   // ---------------- log2 ----------------
   logic [4:0]  msb_ff, msb_in;
   logic [16:0] m_ff, m_in;
   logic signed [4:0] e_ff, e_in;

   always_comb begin
      msb_in = '0;
      for (int b = 1; b < 32; b++) begin
         if (y_ff.y[b]) begin
            msb_in = 5'(b);
         end
      end
   end

   always_comb begin
      logic [47:0] ext;
      ext  = {side_ff[0].y, 16'd0} >> msb_ff;
      m_in = ext[16:0];
      e_in = 5'(msb_ff - 5'd16);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         msb_ff <= msb_in;
         m_ff   <= m_in;
         e_ff   <= e_in;
      end
   end

   sq_type sq_src [FB];
   sq_type sq_ff  [FB];
   sq_type sq_in  [FB];

   generate
      for (s = 0; s < FB; s++) begin : g_sq
         if (s == 0) begin : g_seed
            assign sq_src[s] = '{m: m_ff, e: e_ff, frac: '0};
         end else begin : g_link
            assign sq_src[s] = sq_ff[s-1];
         end

         always_comb begin
            logic [33:0] prod;
            logic [17:0] mm;
            prod = sq_src[s].m * sq_src[s].m;
            mm   = prod[33:16];
            sq_in[s]      = sq_src[s];
            sq_in[s].m    = mm[17] ? mm[17:1] : mm[16:0];
            sq_in[s].frac = {sq_src[s].frac[FB-2:0], mm[17]};
         end

         always_ff @(posedge clock) begin
            if (en) begin
               sq_ff[s] <= sq_in[s];
            end
         end
      end
   endgenerate

   // ---------------- exponent ----------------
   logic signed [25:0] r_ff, r_in;

   always_comb begin
      logic signed [20:0] l_val;
      logic signed [37:0] t;
      l_val = {sq_ff[FB-1].e, sq_ff[FB-1].frac};
      t     = l_val * $signed({1'b0, cfg.gamma_exponent});
      r_in  = t[37:12];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff <= r_in;
      end
   end

   // ---------------- exp2 ----------------
   logic              big_ff [3];
   logic              tiny_ff [3];
   logic signed [5:0] k_ff [3];
   logic [15:0]       f_ff [2];
   logic [14:0]       pa_ff, pa_in;
   logic [16:0]       pb_ff, pb_in;
   logic [17:0]       pc_ff, pc_in;
   logic              big_in, tiny_in;

   always_comb begin
      logic [28:0] prod;
      big_in  = r_ff >= 26'sd1048576;
      tiny_in = r_ff < -26'sd1114112;
      prod    = 29'(r_ff[15:0]) * 29'd5183;
      pa_in   = 15'd14753 + 15'(prod[28:16]);
   end

   always_comb begin
      logic [30:0] prod;
      prod  = 31'(pa_ff) * 31'(f_ff[0]);
      pb_in = 17'd45600 + 17'(prod[30:16]);
   end

   always_comb begin
      logic [32:0] prod;
      prod  = 33'(pb_ff) * 33'(f_ff[1]);
      pc_in = 18'(hpt_pkg::ONE_Q) + 18'(prod[32:16]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         big_ff[0]  <= big_in;
         tiny_ff[0] <= tiny_in;
         k_ff[0]    <= r_ff[21:16];
         f_ff[0]    <= r_ff[15:0];
         pa_ff      <= pa_in;
         big_ff[1]  <= big_ff[0];
         tiny_ff[1] <= tiny_ff[0];
         k_ff[1]    <= k_ff[0];
         f_ff[1]    <= f_ff[0];
         pb_ff      <= pb_in;
         big_ff[2]  <= big_ff[1];
         tiny_ff[2] <= tiny_ff[1];
         k_ff[2]    <= k_ff[1];
         pc_ff      <= pc_in;
      end
   end

   // ---------------- final select ----------------
   logic [31:0] res_ff, res_in;

   always_comb begin
      logic [32:0] sh;
      logic [17:0] shr;
      logic [5:0]  nk;
      logic [31:0] ev, powv, rq;
      side_type    sd;
      sd  = side_ff[LS-1];
      nk  = 6'(-k_ff[2]);
      sh  = {15'd0, pc_ff} << k_ff[2][3:0];
      shr = pc_ff >> nk[4:0];
      if (big_ff[2]) begin
         ev = CEIL;
      end else if (tiny_ff[2]) begin
         ev = '0;
      end else if (!k_ff[2][5]) begin
         ev = (sh > {1'b0, CEIL}) ? CEIL : sh[31:0];
      end else begin
         ev = ({14'd0, shr} > CEIL) ? CEIL : {14'd0, shr};
      end
      if (cfg.gamma_exponent == '0) begin
         powv = ONE_SAT;
      end else if (sd.y == '0) begin
         powv = '0;
      end else begin
         powv = ev;
      end
      rq = ({15'd0, rh_ff[LS-1].nq} > CEIL) ? CEIL : {15'd0, rh_ff[LS-1].nq};
      unique case (sd.mode)
         hpt_pkg::MODE_EQUALIZE,
         hpt_pkg::MODE_CLAMP_NORM:  res_in = sd.y;
         hpt_pkg::MODE_GAMMA:       res_in = powv;
         hpt_pkg::MODE_CLAMP_GAMMA: res_in = (sd.y < hpt_pkg::ONE_Q) ? powv : sd.y;
         hpt_pkg::MODE_REINHARD:    res_in = rq;
         default:                   res_in = sd.bypass;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

@@ sv/hpt_back.sv @@
// ----------------------------------------------------------------------------
// hpt_back: back end of the tone mapper
// Pulls items from the queue into three channel pipelines and tracks
// occupancy; the whole pipeline holds while a result waits on a stall.
// ----------------------------------------------------------------------------
module hpt_back #(
   parameter int SAMPLE_BITS = hpt_pkg::SAMPLE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  hpt_pkg::cfg_type  cfg,
   input  logic              pop_valid,
   output logic              pop,
   input  hpt_pkg::item_type pop_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [31:0]       rsp_red_out,
   output logic [31:0]       rsp_green_out,
   output logic [31:0]       rsp_blue_out
);

   localparam int NS = hpt_pkg::BACK_STAGES;

   logic [NS-1:0] valid_ff, valid_in;
   logic          en;
   logic [hpt_pkg::CHANNELS-1:0][31:0] res;

   // freeze everything while the finished result is held
   assign en  = !(valid_ff[NS-1] && rsp_stall);
   assign pop = en && pop_valid;

   always_comb begin
      valid_in = valid_ff;
      if (en) begin
         valid_in = {valid_ff[NS-2:0], pop};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   genvar c;
   generate
      for (c = 0; c < hpt_pkg::CHANNELS; c++) begin : g_chan
         hpt_chan #(
            .SAMPLE_BITS (SAMPLE_BITS)
         ) u_chan (
            .clock  (clock),
            .en     (en),
            .cfg    (cfg),
            .mode   (pop_item.mode),
            .sel_im (pop_item.sel_im),
            .over   (pop_item.over[c]),
            .x      (pop_item.x[c]),
            .bypass (pop_item.bypass[c]),
            .res    (res[c])
         );
      end
   endgenerate

   assign rsp_valid     = valid_ff[NS-1];
   assign rsp_red_out   = res[0];
   assign rsp_green_out = res[1];
   assign rsp_blue_out  = res[2];

endmodule
